/* sv/mwpo_pkg.sv */
// ----------------------------------------------------------------------------
// mwpo_pkg: shared types and constants of the phase oscillator
// Waveform and register codes, default parameter values and the transaction
// record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mwpo_pkg;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam int STEP_W     = 32;
  localparam int AMP_W      = 15;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  // magnitude of a Q1.30 waveform value, 1.0 included
  localparam int MAG_W      = 31;
  // widest sine table address (largest table size plus one bit)
  localparam int ADDR_MAX_W = 15;

  localparam int QUEUE_DEPTH = 2;
  localparam int BACK_STAGES = 3;

  localparam logic [AMP_W-1:0] AMP_RESET = {AMP_W{1'b1}};

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAWTOOTH = 2'd3
  } wave_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_SELECT = 2'd0,
    CFG_PHASE_STEP  = 2'd1,
    CFG_AMPLITUDE   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                  sine;
    logic                  neg;
    logic [ADDR_MAX_W-1:0] addr;
    logic [MAG_W-1:0]      mag;
  } entry_t;

endpackage

`default_nettype wire

/* sv/multi_waveform_phase_oscillator.sv */
// ----------------------------------------------------------------------------
// multi_waveform_phase_oscillator: phase-accumulator waveform generator
// Each tick transaction yields one signed sample of sine, square, triangle or
// sawtooth at the current phase, scaled by a Q0.15 amplitude.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   -------   ---------  ---------------------  ---------------------------
//   tick      in         in_valid_i/in_ready_o  restart_i
//   sample    out        out_valid_o/out_ready_i sample_o (signed)
//   config    in         cfg_we_i (no wait)     cfg_index_i, cfg_data_i
//
// One tick per clock while in_ready_o is high. A sample passes the queue slot,
// sine table read register, multiplier register and output register in turn.
// Reset clears the phase, register file, queue pointers and valid flags; the
// sine table is a constant ROM and needs no fill. A stalled output fills the
// back end and then the two-entry queue before in_ready_o drops.
//
`default_nettype none

module multi_waveform_phase_oscillator #(
  parameter int PHASE_BITS      = mwpo_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_BITS     = mwpo_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // tick channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              restart_i,
  // sample channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]          sample_o,
  // register writes
  input  wire logic                              cfg_we_i,
  input  wire logic [mwpo_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mwpo_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mwpo_pkg::*;

  wave_e             wave_select_q;
  logic [STEP_W-1:0] phase_step_q;
  logic [AMP_W-1:0]  amplitude_q;

  logic   push, q_full, q_valid, pop;
  entry_t push_entry, pop_entry;

  // Register file: the user writes only with no transaction in flight, as the
  // back end reads amplitude directly; the block does not enforce it. Unknown indexes drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_select_q <= WAVE_SINE;
      phase_step_q  <= '0;
      amplitude_q   <= AMP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WAVE_SELECT: wave_select_q <= wave_e'(cfg_data_i[1:0]);
        CFG_PHASE_STEP:  phase_step_q  <= cfg_data_i[STEP_W-1:0];
        CFG_AMPLITUDE:   amplitude_q   <= cfg_data_i[AMP_W-1:0];
        default:         ;
      endcase
    end
  end

  // Front end: restart, classify the phase, advance the accumulator.
  mwpo_front #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .restart_i    (restart_i),
    .wave_select_i(wave_select_q),
    .phase_step_i (phase_step_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // Decouple the two halves so either side can stall.
  mwpo_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (pop),
    .entry_o(pop_entry)
  );

  // Back end: table read, gain, round and saturate.
  mwpo_back #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .entry_i    (pop_entry),
    .pop_o      (pop),
    .amplitude_i(amplitude_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sample_o   (sample_o)
  );

endmodule

`default_nettype wire

/* sv/mwpo_sine_rom.sv */
// ----------------------------------------------------------------------------
// mwpo_sine_rom: quarter-wave sine table
// Entry k holds sin(pi/2 * k / 2^TABLE_BITS) in Q1.30, built at elaboration
// by an odd series to the x^17 term. Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mwpo_sine_rom #(
  parameter int TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rd_en_i,
  input  wire logic [TABLE_BITS:0]          addr_i,
  output logic      [mwpo_pkg::MAG_W-1:0]   data_o
);
  import mwpo_pkg::*;

  localparam int QUARTER_N = 1 << TABLE_BITS;
  localparam int DEPTH     = QUARTER_N + 1;

  function automatic logic [MAG_W-1:0] sine_entry(input int k);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (64'd1686629713 * 64'(k) + 64'(QUARTER_N / 2)) >> TABLE_BITS;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if ((n & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    return sum[MAG_W-1:0];
  endfunction

  logic [MAG_W-1:0] rom_w [DEPTH];

  // one constant per entry, folded at elaboration
  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    localparam logic [MAG_W-1:0] ENTRY = sine_entry(g);
    assign rom_w[g] = ENTRY;
  end

  logic [MAG_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= rom_w[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

/* sv/mwpo_front.sv */
// ----------------------------------------------------------------------------
// mwpo_front: phase accumulator and waveform classification
// Takes one tick per cycle while the queue is not full, applies restart, turns
// the phase into a table address or a direct magnitude, and advances the phase.
// ----------------------------------------------------------------------------
`default_nettype none

module mwpo_front #(
  parameter int PHASE_BITS      = mwpo_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          restart_i,
  input  wire mwpo_pkg::wave_e               wave_select_i,
  input  wire logic [mwpo_pkg::STEP_W-1:0]   phase_step_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output mwpo_pkg::entry_t                   entry_o
);
  import mwpo_pkg::*;

  localparam logic [SINE_TABLE_BITS:0] QUARTER_N = {1'b1, {SINE_TABLE_BITS{1'b0}}};
  localparam logic signed [32:0] ONE_Q30  = 33'sh0_4000_0000;
  localparam logic signed [32:0] HALF_Q30 = 33'sh0_2000_0000;

  logic [PHASE_BITS-1:0]      phase_q, phase_d;
  logic [PHASE_BITS-1:0]      cur;
  logic [PHASE_BITS-1:0]      step_pb;
  logic [PHASE_BITS+31:0]     step_ext;
  logic [PHASE_BITS+29:0]     f_ext;
  logic [29:0]                f;
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] k;
  logic [SINE_TABLE_BITS:0]   addr;
  logic signed [32:0]         fs, d, abs_d, w;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cur      = restart_i ? '0 : phase_q;
    step_ext = {{PHASE_BITS{1'b0}}, phase_step_i};
    step_pb  = step_ext[PHASE_BITS-1:0];
    // top 30 phase bits as a Q30 fraction
    f_ext    = {cur, 30'b0};
    f        = f_ext[PHASE_BITS+29 -: 30];
    fs       = $signed({3'b000, f});
    quad     = cur[PHASE_BITS-1 -: 2];
    k        = cur[PHASE_BITS-3 -: SINE_TABLE_BITS];
    // odd quadrants run the table backward
    addr     = quad[0] ? (QUARTER_N - {1'b0, k}) : {1'b0, k};
    d        = fs - HALF_Q30;
    abs_d    = d[32] ? -d : d;
    case (wave_select_i)
      WAVE_SQUARE:   w = f[29] ? -ONE_Q30 : ONE_Q30;
      WAVE_TRIANGLE: w = (abs_d <<< 2) - ONE_Q30;
      WAVE_SAWTOOTH: w = (fs <<< 1) - ONE_Q30;
      default:       w = '0;
    endcase
    entry_o.sine = (wave_select_i == WAVE_SINE);
    entry_o.neg  = entry_o.sine ? quad[1] : w[32];
    entry_o.addr = ADDR_MAX_W'(addr);
    entry_o.mag  = w[32] ? MAG_W'(-w) : MAG_W'(w);
    phase_d      = push_o ? (cur + step_pb) : phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

/* sv/mwpo_queue.sv */
// ----------------------------------------------------------------------------
// mwpo_queue: short queue between front end and back end
// Holds classified transactions so that each side may stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module mwpo_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire mwpo_pkg::entry_t  entry_i,
  output logic                   full_o,
  output logic                   valid_o,
  input  wire logic              pop_i,
  output mwpo_pkg::entry_t       entry_o
);
  import mwpo_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

/* sv/mwpo_back.sv */
// ----------------------------------------------------------------------------
// mwpo_back: table lookup, gain and saturation
// Three elastic stages: table read, amplitude multiply, round and saturate
// into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mwpo_back #(
  parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_BITS     = mwpo_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_valid_i,
  input  wire mwpo_pkg::entry_t             entry_i,
  output logic                              pop_o,
  input  wire logic [mwpo_pkg::AMP_W-1:0]   amplitude_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     sample_o
);
  import mwpo_pkg::*;

  localparam int PROD_W    = MAG_W + AMP_W;
  localparam int OUT_SHIFT = PROD_W - SAMPLE_BITS;
  localparam int R_W       = SAMPLE_BITS + 1;
  localparam logic [PROD_W:0]  ROUND_HALF = (PROD_W + 1)'(1) << (OUT_SHIFT - 1);
  localparam logic [R_W-1:0]   POS_MAX    = {2'b00, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [R_W-1:0]   NEG_LIM    = {2'b01, {(SAMPLE_BITS-1){1'b0}}};

  logic                 en_b, en_c, en_o;
  logic                 b_valid_q, b_sine_q, b_neg_q;
  logic [MAG_W-1:0]     b_mag_q, rom_data, mag_sel;
  logic                 c_valid_q, c_neg_q;
  logic [PROD_W-1:0]    c_prod_q, prod_d;
  logic                 o_valid_q;
  logic signed [SAMPLE_BITS-1:0] o_sample_q, sample_d;
  logic [PROD_W:0]      rsum;
  logic [R_W-1:0]       r, neg_r;

  // advance a stage when it is empty or its successor moves
  assign en_o  = !o_valid_q || out_ready_i;
  assign en_c  = !c_valid_q || en_o;
  assign en_b  = !b_valid_q || en_c;
  assign pop_o = q_valid_i && en_b;

  mwpo_sine_rom #(
    .TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .rd_en_i(en_b),
    .addr_i (entry_i.addr[SINE_TABLE_BITS:0]),
    .data_o (rom_data)
  );

  always_comb begin
    mag_sel = b_sine_q ? rom_data : b_mag_q;
    prod_d  = PROD_W'(mag_sel) * PROD_W'(amplitude_i);
    rsum    = {1'b0, c_prod_q} + ROUND_HALF;
    r       = rsum[PROD_W:OUT_SHIFT];
    neg_r   = -r;
    if (!c_neg_q) begin
      sample_d = (r > POS_MAX) ? $signed(POS_MAX[SAMPLE_BITS-1:0])
                               : $signed(r[SAMPLE_BITS-1:0]);
    end else begin
      sample_d = (r > NEG_LIM) ? $signed(NEG_LIM[SAMPLE_BITS-1:0])
                               : $signed(neg_r[SAMPLE_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b_sine_q <= entry_i.sine;
      b_neg_q  <= entry_i.neg;
      b_mag_q  <= entry_i.mag;
    end
    if (en_c) begin
      c_neg_q  <= b_neg_q;
      c_prod_q <= prod_d;
    end
    if (en_o) begin
      o_sample_q <= sample_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (en_b) begin
        b_valid_q <= pop_o;
      end
      if (en_c) begin
        c_valid_q <= b_valid_q;
      end
      if (en_o) begin
        o_valid_q <= c_valid_q;
      end
    end
  end

  assign out_valid_o = o_valid_q;
  assign sample_o    = o_sample_q;

endmodule

`default_nettype wire

/* sv/mwpo_checker.sv */
// ----------------------------------------------------------------------------
// mwpo_checker: port-level checks of the phase oscillator
// Tracks transactions in flight and checks the reset, input and output sides over time.
// ----------------------------------------------------------------------------
`default_nettype none

module mwpo_checker #(
  parameter int SAMPLE_BITS = mwpo_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic                             in_ready_o,
  input  wire logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  input  wire logic signed [SAMPLE_BITS-1:0]    sample_o
);
  import mwpo_pkg::*;

  localparam int CAPACITY = QUEUE_DEPTH + BACK_STAGES;
  localparam int CNT_W    = $clog2(CAPACITY + 2);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] inflight_q, inflight_d;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + 1'b1;
    end else if (out_acc && !in_acc && inflight_q != '0) begin
      inflight_d = inflight_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("sample valid during reset");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> inflight_q != '0)
    else $error("sample delivered with no tick in flight");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(CAPACITY))
    else $error("more ticks in flight than the block can hold");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == '0 |-> in_ready_o)
    else $error("tick refused while nothing is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o))
    else $error("stalled sample dropped or changed");

endmodule

bind multi_waveform_phase_oscillator mwpo_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_mwpo_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .sample_o   (sample_o)
);

`default_nettype wire
